[rtl/gpbe_pkg.sv]
`timescale 1ns / 1ps

package gpbe_pkg;

	// LED count and derived sizes
	localparam int LED_COUNT   = 40;
	localparam int LEVEL_COUNT = 64;
	localparam int BYTE_COUNT  = (LED_COUNT + 7) / 8;
	localparam int LED_W       = $clog2(LED_COUNT);
	localparam int BANK_W      = $clog2(2 * LED_COUNT);
	localparam int LEVEL_W     = $clog2(LEVEL_COUNT);
	localparam int PULSE_W     = 7;

	typedef enum logic [2:0] {
		CMD_SET_BRT = 3'd0,
		CMD_REN_ONE = 3'd1,
		CMD_REN_ALL = 3'd2,
		CMD_SWAP    = 3'd3,
		CMD_SEND    = 3'd4
	} cmd_code_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [5:0] led_index;
		logic [5:0] brightness;
		logic [5:0] step_index;
	} item_t;

	typedef struct packed {
		logic [2:0] byte_index;
		logic [7:0] step_bits;
		logic       last;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic             bri_wr;
		logic             swap;
		logic             step_ld;
		logic             ren_rd;
		logic             snd_rd;
		logic [LED_W-1:0] idx;
	} dp_cmd_t;

endpackage

[rtl/gpbe_ctrl.sv]
`timescale 1ns / 1ps

module gpbe_ctrl import gpbe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output dp_cmd_t dp_cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_REN   = 4'b0010,
		S_SEND  = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	localparam logic [LED_W-1:0] LAST_IDX = LED_W'(LED_COUNT - 1);

	state_t           state_q, state_nxt;
	logic [LED_W-1:0] cnt_q, cnt_nxt;
	logic             single_q, single_nxt;
	logic             accept;
	logic             led_ok;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign led_ok = (32'(item.led_index) < 32'(LED_COUNT));

	always_comb begin
		state_nxt  = state_q;
		cnt_nxt    = cnt_q;
		single_nxt = single_q;
		dp_cmd     = '0;
		dp_cmd.idx = cnt_q;
		case (state_q)
			S_IDLE: begin
				dp_cmd.idx = LED_W'(item.led_index);
				if (accept) begin
					case (item.cmd)
						CMD_SET_BRT: dp_cmd.bri_wr = led_ok;
						CMD_REN_ONE: begin
							if (led_ok) begin
								cnt_nxt    = LED_W'(item.led_index);
								single_nxt = 1'b1;
								state_nxt  = S_REN;
							end
						end
						CMD_REN_ALL: begin
							cnt_nxt    = '0;
							single_nxt = 1'b0;
							state_nxt  = S_REN;
						end
						CMD_SWAP: dp_cmd.swap = 1'b1;
						CMD_SEND: begin
							dp_cmd.step_ld = 1'b1;
							cnt_nxt        = '0;
							state_nxt      = S_SEND;
						end
						default: ;
					endcase
				end
			end
			S_REN: begin
				dp_cmd.ren_rd = 1'b1;
				if (single_q || cnt_q == LAST_IDX) begin
					state_nxt = S_FLUSH;
				end else begin
					cnt_nxt = cnt_q + 1'b1;
				end
			end
			S_SEND: begin
				dp_cmd.snd_rd = 1'b1;
				if (cnt_q == LAST_IDX) begin
					state_nxt = S_FLUSH;
				end else begin
					cnt_nxt = cnt_q + 1'b1;
				end
			end
			S_FLUSH: state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			single_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			cnt_q    <= cnt_nxt;
			single_q <= single_nxt;
		end
	end

endmodule

[rtl/gpbe_datapath.sv]
`timescale 1ns / 1ps

module gpbe_datapath import gpbe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  dp_cmd_t dp_cmd,
	output logic    strobe,
	output result_t result
);

	localparam logic [PULSE_W-1:0] GAMMA_ROM [LEVEL_COUNT] = '{
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h01,
		7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h02, 7'h02,
		7'h02, 7'h02, 7'h02, 7'h03, 7'h03, 7'h03, 7'h03, 7'h04,
		7'h04, 7'h04, 7'h05, 7'h05, 7'h05, 7'h06, 7'h06, 7'h07,
		7'h07, 7'h08, 7'h09, 7'h09, 7'h0a, 7'h0b, 7'h0b, 7'h0c,
		7'h0d, 7'h0e, 7'h0f, 7'h10, 7'h11, 7'h13, 7'h14, 7'h16,
		7'h17, 7'h19, 7'h1a, 7'h1c, 7'h1e, 7'h21, 7'h23, 7'h25,
		7'h28, 7'h2b, 7'h2e, 7'h31, 7'h34, 7'h38, 7'h3c, 7'h40
	};

	localparam logic [LED_W-1:0] LAST_IDX = LED_W'(LED_COUNT - 1);

	function automatic logic [BANK_W-1:0] bank_addr(input logic b, input logic [LED_W-1:0] i);
		return b ? (BANK_W'(LED_COUNT) + BANK_W'(i)) : BANK_W'(i);
	endfunction

	logic [LEVEL_W-1:0] bri_mem  [LED_COUNT];
	logic [PULSE_W-1:0] bank_mem [2*LED_COUNT];
	logic [LED_COUNT-1:0]   bri_vld_q;
	logic [2*LED_COUNT-1:0] bank_vld_q;

	logic               active_q;
	logic [5:0]         step_q;
	logic               ren_s1, snd_s1;
	logic [LED_W-1:0]   idx_s1;
	logic               tgt_s1;
	logic               vld_s1;
	logic [LEVEL_W-1:0] bri_s1;
	logic [PULSE_W-1:0] pl_s1;
	logic [7:0]         acc_q, acc_nxt;
	logic               hit;
	logic               byte_end;
	logic [BANK_W-1:0]  wr_addr;
	logic [BANK_W-1:0]  rd_addr;
	logic [LEVEL_W-1:0] level;
	logic [2:0]         bit_pos;

	assign rd_addr = bank_addr(active_q, dp_cmd.idx);
	assign wr_addr = bank_addr(tgt_s1, idx_s1);
	assign level   = vld_s1 ? bri_s1 : '0;
	assign bit_pos = idx_s1[2:0];

	// memories and their read registers, no reset
	always_ff @(posedge clk) begin
		if (dp_cmd.bri_wr) begin
			bri_mem[dp_cmd.idx] <= item.brightness;
		end
		if (dp_cmd.ren_rd) begin
			bri_s1 <= bri_mem[dp_cmd.idx];
		end
		if (ren_s1) begin
			bank_mem[wr_addr] <= GAMMA_ROM[level];
		end
		if (dp_cmd.snd_rd) begin
			pl_s1 <= bank_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bri_vld_q  <= '0;
			bank_vld_q <= '0;
			active_q   <= 1'b0;
			ren_s1     <= 1'b0;
			snd_s1     <= 1'b0;
			strobe     <= 1'b0;
		end else begin
			if (dp_cmd.bri_wr) begin
				bri_vld_q[dp_cmd.idx] <= 1'b1;
			end
			if (ren_s1) begin
				bank_vld_q[wr_addr] <= 1'b1;
			end
			if (dp_cmd.swap) begin
				active_q <= ~active_q;
			end
			ren_s1 <= dp_cmd.ren_rd;
			snd_s1 <= dp_cmd.snd_rd;
			strobe <= snd_s1 && byte_end;
		end
	end

	// stage-1 payload, step register, byte accumulator and result word
	always_ff @(posedge clk) begin
		idx_s1 <= dp_cmd.idx;
		tgt_s1 <= ~active_q;
		if (dp_cmd.ren_rd) begin
			vld_s1 <= bri_vld_q[dp_cmd.idx];
		end else if (dp_cmd.snd_rd) begin
			vld_s1 <= bank_vld_q[rd_addr];
		end
		if (dp_cmd.step_ld) begin
			step_q <= item.step_index;
		end
		if (snd_s1) begin
			acc_q <= acc_nxt;
		end
		if (snd_s1 && byte_end) begin
			result.byte_index <= 3'(idx_s1 >> 3);
			result.step_bits  <= acc_nxt;
			result.last       <= (idx_s1 == LAST_IDX);
		end
	end

	always_comb begin
		hit      = vld_s1 && (pl_s1 > {1'b0, step_q});
		byte_end = (bit_pos == 3'd7) || (idx_s1 == LAST_IDX);
		acc_nxt  = (bit_pos == 3'd0) ? 8'd0 : acc_q;
		acc_nxt[bit_pos] = acc_nxt[bit_pos] | hit;
	end

endmodule

[rtl/gamma_pwm_led_bitplane_engine_top.sv]
`timescale 1ns / 1ps

// Gamma-corrected PWM bit-plane engine for LED_COUNT (40) LEDs. Issue a command word on
// item with start high while busy is low; it is taken at that clock edge. Set brightness
// and swap banks finish in the accepting cycle and never raise busy. Render one holds
// busy through S_REN and S_FLUSH; render all and send step walk every LED through the single
// read port of the brightness or pulse-length memory, one LED per cycle, and hold busy for
// the walk and then S_FLUSH. Send step emits BYTE_COUNT (5) result words, one per group of
// eight LEDs, each marked by a one-cycle strobe; the last word carries last = 1 and appears
// in the first cycle with busy low. The receiver cannot stall: capture every word on the
// cycle strobe is high. Render writes the inactive bank, so a render followed by swap
// updates all LEDs at once. Out-of-range LED indexes and unused command codes are
// dropped. All stores read as zero after reset; no clearing pass is needed.
module gamma_pwm_led_bitplane_engine_top import gpbe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    strobe,
	output result_t result
);

	dp_cmd_t dp_cmd;

	// sequence commands: count LEDs, issue memory reads, drain the read stage
	gpbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.dp_cmd (dp_cmd)
	);

	// hold brightness and both pulse-length banks, apply gamma, pack bit planes
	gpbe_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.dp_cmd (dp_cmd),
		.strobe (strobe),
		.result (result)
	);

`ifndef NO_ASSERTIONS
	// every word is produced from a read issued while busy
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result word without a preceding busy cycle");

	// the last flag marks only the final byte
	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |-> (result.byte_index == 3'(BYTE_COUNT - 1)))
		else $error("last flag on a byte other than the final one");

	// byte index stays within the plane
	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (32'(result.byte_index) < 32'(BYTE_COUNT)))
		else $error("byte index beyond the plane");

	// an accepted send word starts a walk
	a_send_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_SEND) |=> busy)
		else $error("send command did not raise busy");
`endif

endmodule

[tb/gamma_pwm_led_bitplane_engine_top_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the gamma PWM bit-plane engine.
// Commands go in on the start/busy handshake, one word per accepted edge.
// A behavioral copy of the engine tracks brightness, both pulse-length banks and
// the active bank. On every accepted send step it queues the five bit-plane
// bytes that the engine must emit. Each strobed byte is checked field by field
// against the oldest queued byte.
module gamma_pwm_led_bitplane_engine_top_test;
	import gpbe_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DIR_ROWS     = 25;
	localparam int PHASE_WORDS  = 40;
	localparam int DRAIN_CYCLES = 60;
	localparam int PRINT_CAP    = 40;

	// fixed gamma curve: 6-bit brightness to pulse length 0..64
	localparam logic [6:0] GAMMA_CURVE [LEVEL_COUNT] = '{
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h01,
		7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h02, 7'h02,
		7'h02, 7'h02, 7'h02, 7'h03, 7'h03, 7'h03, 7'h03, 7'h04,
		7'h04, 7'h04, 7'h05, 7'h05, 7'h05, 7'h06, 7'h06, 7'h07,
		7'h07, 7'h08, 7'h09, 7'h09, 7'h0a, 7'h0b, 7'h0b, 7'h0c,
		7'h0d, 7'h0e, 7'h0f, 7'h10, 7'h11, 7'h13, 7'h14, 7'h16,
		7'h17, 7'h19, 7'h1a, 7'h1c, 7'h1e, 7'h21, 7'h23, 7'h25,
		7'h28, 7'h2b, 7'h2e, 7'h31, 7'h34, 7'h38, 7'h3c, 7'h40
	};

	// One row of the directed table. When known is set, every byte of a send step
	// must carry plane; otherwise the behavioral engine decides.
	typedef struct {
		item_t      word;
		bit         known;
		logic [7:0] plane;
	} stim_row_t;

	typedef struct {
		bit         known;
		logic [7:0] plane;
	} typed_plane_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    strobe;
	result_t result;

	// behavioral copy of the engine state
	logic [5:0] led_level [LED_COUNT];
	logic [6:0] pulse_len [2][LED_COUNT];
	logic       front_bank;

	result_t      plane_bytes_due [$];
	typed_plane_t typed_plane_q [$];
	stim_row_t    directed_rows [DIR_ROWS];

	int          error_count;
	int unsigned gap_pct;
	bit          row_typed;
	logic [7:0]  row_plane;

	gamma_pwm_led_bitplane_engine_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	// Advance the behavioral engine by one accepted command word. A send step
	// queues one byte per group of eight LEDs; when typed is set, the typed plane
	// replaces the computed bits.
	task automatic advance_engine(item_t w, bit typed, logic [7:0] typed_bits);
		logic       target;
		logic [7:0] bits;
		int         n;
		target = ~front_bank;
		case (w.cmd)
			CMD_SET_BRT: begin
				if (w.led_index < LED_COUNT)
					led_level[w.led_index] = w.brightness;
			end
			CMD_REN_ONE: begin
				if (w.led_index < LED_COUNT)
					pulse_len[target][w.led_index] = GAMMA_CURVE[led_level[w.led_index]];
			end
			CMD_REN_ALL: begin
				for (int i = 0; i < LED_COUNT; i++)
					pulse_len[target][i] = GAMMA_CURVE[led_level[i]];
			end
			CMD_SWAP: begin
				front_bank = target;
			end
			CMD_SEND: begin
				for (int b = 0; b < BYTE_COUNT; b++) begin
					bits = '0;
					for (int k = 0; k < 8; k++) begin
						n = b * 8 + k;
						// LEDs past the end of the string read as dark
						if (n < LED_COUNT && pulse_len[front_bank][n] > {1'b0, w.step_index})
							bits[k] = 1'b1;
					end
					if (typed)
						bits = typed_bits;
					plane_bytes_due.push_back('{byte_index: 3'(b), step_bits: bits,
						last: (b == BYTE_COUNT - 1)});
				end
			end
			default: begin
				// unused command codes: drop
			end
		endcase
	endtask

	// True when a word changes state or produces output.
	function automatic bit takes_effect(item_t w);
		if (w.cmd > CMD_SEND)
			return 1'b0;
		if ((w.cmd == CMD_SET_BRT || w.cmd == CMD_REN_ONE) && w.led_index >= LED_COUNT)
			return 1'b0;
		return 1'b1;
	endfunction

	// Mostly brightness updates, renders, swaps and sends with random content;
	// a tenth of LED indexes fall past the end and a few words carry unused codes.
	function automatic item_t random_word();
		item_t w;
		int    pick;
		if ($urandom_range(9) == 0)
			w.led_index = 6'($urandom_range(63, LED_COUNT));
		else
			w.led_index = 6'($urandom_range(LED_COUNT - 1));
		w.brightness = 6'($urandom_range(63));
		// favor low steps, where most gamma-mapped pulse lengths end
		if ($urandom_range(1) == 0)
			w.step_index = 6'($urandom_range(15));
		else
			w.step_index = 6'($urandom_range(63));
		pick = $urandom_range(99);
		if (pick < 34)
			w.cmd = CMD_SET_BRT;
		else if (pick < 50)
			w.cmd = CMD_REN_ONE;
		else if (pick < 58)
			w.cmd = CMD_REN_ALL;
		else if (pick < 70)
			w.cmd = CMD_SWAP;
		else if (pick < 95)
			w.cmd = CMD_SEND;
		else
			w.cmd = 3'($urandom_range(7, CMD_SEND + 1));
		return w;
	endfunction

	// Hold the word with start high until an edge sees busy low, then maybe idle.
	// Leave start high when no idle follows so back-to-back words stay back to back.
	task automatic issue_word(item_t w);
		start <= 1'b1;
		item  <= w;
		do
			@(posedge clk);
		while (busy);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			item  <= random_word();
			do
				@(posedge clk);
			while ($urandom_range(99) < gap_pct);
		end
	endtask

	// Check strobed bytes first, then take the accepted command; a byte can never
	// belong to a send accepted on the same edge.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (plane_bytes_due.size() == 0) begin
				flag_mismatch("byte with nothing due", result, 0);
			end else begin
				result_t due;
				due = plane_bytes_due.pop_front();
				if (result.byte_index !== due.byte_index)
					flag_mismatch("byte_index", result.byte_index, due.byte_index);
				if (result.step_bits !== due.step_bits)
					flag_mismatch("step_bits", result.step_bits, due.step_bits);
				if (result.last !== due.last)
					flag_mismatch("last", result.last, due.last);
			end
		end
		if (arst_n && start && !busy) begin
			row_typed = 1'b0;
			row_plane = '0;
			if (item.cmd == CMD_SEND && typed_plane_q.size() != 0) begin
				typed_plane_t t;
				t = typed_plane_q.pop_front();
				row_typed = t.known;
				row_plane = t.plane;
			end
			advance_engine(item, row_typed, row_plane);
		end
	end

	// Watchdog: end the run if the engine stops answering.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("gamma_pwm_led_bitplane_engine_top_test: done, errors");
		$finish;
	end

	initial begin
		int counted;
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		error_count = 0;
		gap_pct     = 9;
		front_bank  = 1'b0;
		for (int i = 0; i < LED_COUNT; i++) begin
			led_level[i]    = '0;
			pulse_len[0][i] = '0;
			pulse_len[1][i] = '0;
		end

		// Directed table. Known planes: both banks read dark after reset, and a
		// render only touches the hidden bank until a swap.
		directed_rows = '{
			'{'{CMD_SEND,    6'd0,  6'd0,  6'd0},  1'b1, 8'h00}, // send after reset
			'{'{CMD_SEND,    6'd63, 6'd63, 6'd63}, 1'b1, 8'h00}, // top step, all fields max
			'{'{CMD_SET_BRT, 6'd0,  6'd63, 6'd0},  1'b0, 8'h00}, // first LED, full
			'{'{CMD_SET_BRT, 6'd39, 6'd63, 6'd0},  1'b0, 8'h00}, // last LED, full
			'{'{CMD_SET_BRT, 6'd40, 6'd63, 6'd0},  1'b0, 8'h00}, // one past the end: drop
			'{'{CMD_SET_BRT, 6'd63, 6'd63, 6'd63}, 1'b0, 8'h00}, // largest index: drop
			'{'{CMD_SET_BRT, 6'd1,  6'd7,  6'd0},  1'b0, 8'h00}, // first level with a pulse
			'{'{CMD_SET_BRT, 6'd2,  6'd6,  6'd0},  1'b0, 8'h00}, // last level without
			'{'{CMD_REN_ONE, 6'd0,  6'd0,  6'd0},  1'b0, 8'h00},
			'{'{CMD_REN_ONE, 6'd63, 6'd0,  6'd0},  1'b0, 8'h00}, // out of range: drop
			'{'{CMD_REN_ALL, 6'd0,  6'd0,  6'd0},  1'b0, 8'h00},
			'{'{CMD_SEND,    6'd0,  6'd0,  6'd0},  1'b1, 8'h00}, // hidden bank only
			'{'{CMD_SWAP,    6'd0,  6'd0,  6'd0},  1'b0, 8'h00},
			'{'{CMD_SEND,    6'd0,  6'd0,  6'd0},  1'b0, 8'h00},
			'{'{CMD_SEND,    6'd0,  6'd0,  6'd63}, 1'b0, 8'h00}, // full pulse beats top step
			'{'{CMD_SEND,    6'd0,  6'd0,  6'd1},  1'b0, 8'h00},
			'{'{3'd5,        6'd0,  6'd0,  6'd0},  1'b0, 8'h00}, // unused codes: drop
			'{'{3'd7,        6'd63, 6'd63, 6'd63}, 1'b0, 8'h00},
			'{'{3'd6,        6'd21, 6'd42, 6'd21}, 1'b0, 8'h00},
			'{'{CMD_SWAP,    6'd0,  6'd0,  6'd0},  1'b0, 8'h00},
			'{'{CMD_SEND,    6'd0,  6'd0,  6'd0},  1'b1, 8'h00}, // back to the unrendered bank
			'{'{CMD_SET_BRT, 6'd39, 6'd0,  6'd0},  1'b0, 8'h00},
			'{'{CMD_REN_ONE, 6'd39, 6'd0,  6'd0},  1'b0, 8'h00},
			'{'{CMD_SWAP,    6'd0,  6'd0,  6'd0},  1'b0, 8'h00},
			'{'{CMD_SEND,    6'd0,  6'd0,  6'd62}, 1'b0, 8'h00}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the table; every send row hands its plane to the checker first.
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (directed_rows[r].word.cmd == CMD_SEND)
				typed_plane_q.push_back('{known: directed_rows[r].known,
					plane: directed_rows[r].plane});
			issue_word(directed_rows[r].word);
		end

		// Random part in three idling phases: sparse gaps, dense gaps, none.
		for (int phase = 0; phase < 3; phase++) begin
			item_t w;
			gap_pct = (phase == 0) ? 9 : (phase == 1) ? 83 : 0;
			counted = 0;
			while (counted < PHASE_WORDS) begin
				w = random_word();
				if (takes_effect(w))
					counted++;
				issue_word(w);
			end
		end
		start <= 1'b0;

		// Drain every byte still due, then let the engine settle.
		while (plane_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("gamma_pwm_led_bitplane_engine_top_test: done, clean");
		else
			$display("gamma_pwm_led_bitplane_engine_top_test: done, errors");
		$finish;
	end

endmodule
